// ----- hdl/rgbpal_pkg.sv -----
// Package for the RGB888 to 16-bit colour converter.
// Holds the controller state type, register indexes, colour mode codes,
// dither constants and the checkerboard bump function. No dependencies.
package rgbpal_pkg;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_COLOR_MODE = 2'd0;
	localparam logic [1:0] CFG_FRAME_WIDTH = 2'd1;
	localparam logic [1:0] CFG_INTERLACE = 2'd2;

	// Colour mode codes; the spare code behaves as packed RGB565
	localparam logic [1:0] MODE_PALETTE = 2'd0;
	localparam logic [1:0] MODE_RGB555 = 2'd1;
	localparam logic [1:0] MODE_RGB565 = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Reset values and limits
	localparam int DEFAULT_PALETTE_DEPTH = 256;
	localparam logic [9:0] FRAME_WIDTH_RESET = 10'd256;
	localparam logic [9:0] FRAME_WIDTH_MAX = 10'd512;

	// Checkerboard dither steps and upper bounds
	localparam logic [7:0] DITHER_STEP = 8'h04;
	localparam logic [7:0] DITHER_HIGH = 8'hFC;
	localparam logic [7:0] GREEN_STEP = 8'h02;
	localparam logic [7:0] GREEN_HIGH = 8'hFE;

	// Add step to a channel that lies within [step, high)
	function automatic logic [7:0] bump(input logic [7:0] v, input logic [7:0] step,
		input logic [7:0] high);
		logic [7:0] r;
		r = v;
		if (v >= step && v < high) begin
			r = v + step;
		end
		return r;
	endfunction

endpackage

// ----- hdl/rgb_to_rgb15_palette_converter.sv -----
// Top level of the RGB888 to 16-bit colour converter with dither and palette.
// Depends on rgbpal_pkg for types, codes and dither constants.
// Palette entries live in an on-chip synchronous memory inside this module.

// One result per pixel. In the direct modes (1, 2 and 3) a pixel is first taken in
// and dithered into the working register, then placed in the output register.
// In palette mode (0) the palette memory is scanned one entry a cycle through its
// single registered read port between these steps, until a match or the last
// used entry. The palette is emptied at each frame end by resetting its fill
// count; there is no clearing pass after reset. A finished result waits in the
// output register while the next pixel is taken in.
module rgb_to_rgb15_palette_converter #(
	parameter int PALETTE_DEPTH = rgbpal_pkg::DEFAULT_PALETTE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// pixel input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic        s_axis_tuser,  // screen_select
	input  logic        s_axis_tlast,  // last_in_frame
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // pixel_value [15:0], keep_pixel [16],
	                                    // new_entry [17], entry_color [33:18],
	                                    // palette_full [34], zero [39:35]
	output logic        m_axis_tlast   // frame_end
);
	import rgbpal_pkg::*;

	localparam int IW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int UW = $clog2(PALETTE_DEPTH + 1);

	// Configuration registers
	logic [1:0] color_mode_q;
	logic [9:0] frame_width_q;
	logic       interlace_q;

	// Frame position state
	logic [8:0] column_q;
	logic       phase_q;
	logic       row_par_q;
	logic [1:0] field_par_q;
	logic [UW-1:0] used_q;

	// Palette memory and its read port
	logic [15:0] palette_mem [PALETTE_DEPTH];
	logic [15:0] rd_data_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] ptr_q;

	// Pixel under work
	logic [15:0] color_s1;
	logic        keep_s1;
	logic        scr_s1;
	logic        last_s1;
	logic        hit_q;

	// Output register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	state_t state_q, state_d;

	logic       accept;
	logic       finish;
	logic       is_palette;
	logic       is_565;
	logic       search_hit;
	logic       search_end;
	logic       has_room;
	logic       append;
	logic [7:0] r_d, g_d, b_d;
	logic [15:0] color_d;
	logic [15:0] pix_d;
	logic [9:0] eff_width;
	logic [9:0] next_col;
	logic       row_end;

	assign is_palette = (color_mode_q == MODE_PALETTE);
	assign is_565 = (color_mode_q == MODE_RGB565) || (color_mode_q == MODE_SPARE);
	assign has_room = (used_q != UW'(PALETTE_DEPTH));
	assign search_hit = (rd_data_q == color_s1);
	assign search_end = ((UW'(ptr_q) + UW'(1)) == used_q);

	// Dither and pack the incoming pixel
	always_comb begin
		r_d = s_axis_tdata[7:0];
		g_d = s_axis_tdata[15:8];
		b_d = s_axis_tdata[23:16];
		if (!is_palette && phase_q) begin
			r_d = bump(r_d, DITHER_STEP, DITHER_HIGH);
			g_d = is_565 ? bump(g_d, GREEN_STEP, GREEN_HIGH)
			             : bump(g_d, DITHER_STEP, DITHER_HIGH);
			b_d = bump(b_d, DITHER_STEP, DITHER_HIGH);
		end
		color_d = {(color_mode_q == MODE_RGB555) ? 1'b1 : g_d[2],
			b_d[7:3], g_d[7:3], r_d[7:3]};
	end

	// Effective row width and row end
	always_comb begin
		eff_width = frame_width_q;
		if (frame_width_q == 10'd0) begin
			eff_width = 10'd1;
		end else if (frame_width_q > FRAME_WIDTH_MAX) begin
			eff_width = FRAME_WIDTH_MAX;
		end
		next_col = {1'b0, column_q} + 10'd1;
		row_end = (next_col >= eff_width);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (is_palette && used_q != '0) ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (search_hit || search_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and result forming
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		accept = s_axis_tvalid && s_axis_tready;
		finish = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
		append = is_palette && !hit_q && has_room;
		rd_addr = (state_q == ST_SEARCH) ? ptr_q + IW'(1) : '0;
		if (!is_palette) begin
			pix_d = color_s1;
		end else if (hit_q) begin
			pix_d = {{(16 - IW){1'b0}}, ptr_q};
		end else if (has_room) begin
			pix_d = {{(16 - UW){1'b0}}, used_q};
		end else begin
			pix_d = '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	// Palette memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (finish && append) begin
			palette_mem[used_q[IW-1:0]] <= color_s1;
		end
		rd_data_q <= palette_mem[rd_addr];
	end

	// Hold the pixel under work and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			color_s1 <= color_d;
			keep_s1 <= !interlace_q || (row_par_q == field_par_q[s_axis_tuser]);
			scr_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
		if (finish) begin
			out_data_q <= {5'd0, is_palette && !hit_q && !has_room,
				append ? color_s1 : 16'd0, append, keep_s1, pix_d};
			out_last_q <= last_s1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			color_mode_q <= MODE_PALETTE;
			frame_width_q <= FRAME_WIDTH_RESET;
			interlace_q <= 1'b0;
			column_q <= '0;
			phase_q <= 1'b0;
			row_par_q <= 1'b0;
			field_par_q <= '0;
			used_q <= '0;
			ptr_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLOR_MODE: color_mode_q <= cfg_data[1:0];
					CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
					CFG_INTERLACE: interlace_q <= cfg_data[0];
					default: ;
				endcase
			end

			// start or advance the palette scan
			if (accept) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				if (search_hit) begin
					hit_q <= 1'b1;
				end else if (!search_end) begin
					ptr_q <= ptr_q + IW'(1);
				end
			end

			// drop a taken result, load a new one
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// advance the frame position once the result is formed
			if (finish) begin
				if (last_s1) begin
					column_q <= '0;
					phase_q <= 1'b0;
					row_par_q <= 1'b0;
					used_q <= '0;
					if (interlace_q) begin
						field_par_q[scr_s1] <= !field_par_q[scr_s1];
					end
				end else begin
					if (append) begin
						used_q <= used_q + UW'(1);
					end
					if (row_end) begin
						column_q <= '0;
						row_par_q <= !row_par_q;
					end else begin
						column_q <= next_col[8:0];
						if (!is_palette) begin
							phase_q <= !phase_q;
						end
					end
				end
			end
		end
	end

	// Fill count never passes the palette depth
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(PALETTE_DEPTH))
		else $error("palette fill count beyond depth");

	// The scan only visits entries that were written this frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (UW'(ptr_q) < used_q))
		else $error("palette scan past fill count");

	// A result never both appends and reports a full palette
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[17] && out_data_q[34]))
		else $error("new entry and full flag together");

	// An append within a frame grows the fill count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(finish && append && !last_s1) |=> (used_q == $past(used_q) + UW'(1)))
		else $error("fill count not advanced on append");

endmodule
